[rtl/core/load_store_queue_issue_unit_defines.svh]
// Assertion macros for the load/store queue issue unit.
`ifndef LOAD_STORE_QUEUE_ISSUE_UNIT_DEFINES_SVH
`define LOAD_STORE_QUEUE_ISSUE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LSQ_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define LSQ_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define LSQ_ASSERT_IMP(label, clk, rst, a, c, msg)
`define LSQ_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

[rtl/core/lsq_pkg.sv]
// ----------------------------------------------------------------------------
// lsq_pkg
// Types and constants shared by the load/store queue issue unit.
// ----------------------------------------------------------------------------
`default_nettype none
package lsq_pkg;
  localparam int SLOTS       = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_CHUNKS  = 8;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = 2;
  localparam int SIZE_MAX_OK = 1048576;

  localparam logic [2:0] F_LOAD = 3'd0, F_STORE = 3'd1, F_SPILL = 3'd2, F_SALIAS = 3'd3,
                         F_LALIAS = 3'd4, F_READY = 3'd5, F_TICK = 3'd6, F_RESP = 3'd7;
  localparam logic [2:0] K_ACK = 3'd0, K_ALIAS = 3'd1, K_MEM = 3'd2, K_DONE = 3'd3,
                         K_TEND = 3'd4;
  localparam logic [1:0] ST_OK = 2'd0, ST_FULL = 2'd1, ST_SIZE = 2'd2, ST_STRAY = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] mem_addr;
    logic        mem_write;
    logic [1:0]  slot;
    logic [9:0]  alias_reg;
    logic        found;
    logic [7:0]  done_tag;
    logic        idle;
    logic [1:0]  status;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

[rtl/core/load_store_queue_issue_unit.sv]
// ----------------------------------------------------------------------------
// load_store_queue_issue_unit
// Load and store queues with alias lookup and chunked memory request issue.
// ----------------------------------------------------------------------------
// Usage: one request channel (in_valid/in_ready, func and operands), one
// result channel (out_valid/out_ready), one config channel that writes
// request_width. Each request gives one or more results; the final one has
// last set. A single sequencer walks the queues one entry per cycle and
// finishes each request before it takes the next. A tick fills each free
// slot with the oldest ready entry (scan plus compaction), issues its
// chunks, then runs the slot retire checks with one result per completion
// and ends with the tick end result. The first result passes the dispatch
// and emit steps (and the response step for a response) before it shows.
// Results wait in a one-deep output register; while the receiver stalls
// the sequencer holds in its emit step. Reset empties both queues and frees
// all slots; width returns to 64. in_ready is high only when the sequencer
// is idle.
`default_nettype none
`include "load_store_queue_issue_unit_defines.svh"
module load_store_queue_issue_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  func,
  input  wire logic [47:0] addr,
  input  wire logic [20:0] size,
  input  wire logic [9:0]  phys_reg,
  input  wire logic [7:0]  instr_tag,
  input  wire logic        ready_now,
  input  wire logic        quash_store,
  input  wire logic [1:0]  resp_slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic [47:0]      mem_addr,
  output logic             mem_write,
  output logic [1:0]       slot,
  output logic [9:0]       alias_reg,
  output logic             found,
  output logic [7:0]       done_tag,
  output logic             idle,
  output logic [1:0]       status,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data
);
  import lsq_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DISP  = 11'b00000000010,
    S_SCAN  = 11'b00000000100,
    S_SHIFT = 11'b00000001000,
    S_ISLOT = 11'b00000010000,
    S_CHUNK = 11'b00000100000,
    S_RET   = 11'b00001000000,
    S_TEND  = 11'b00010000000,
    S_EMIT  = 11'b00100000000,
    S_WAIT  = 11'b01000000000,
    S_RESP  = 11'b10000000000
  } state_t;

  state_t state, ret_state;

  logic [12:0] request_width;
  logic [12:0] w;
  assign w = (request_width == 13'd0) ? 13'd1 :
             (request_width > 13'd4096) ? 13'd4096 : request_width;

  // queues: [0] load, [1] store
  logic [47:0] q_addr [2][QUEUE_DEPTH];
  logic [20:0] q_size [2][QUEUE_DEPTH];
  logic [9:0]  q_reg  [2][QUEUE_DEPTH];
  logic [7:0]  q_tag  [2][QUEUE_DEPTH];
  logic        q_rdy  [2][QUEUE_DEPTH];
  logic        q_spill[QUEUE_DEPTH];
  logic [CW-1:0] cnt [2];

  logic              sl_busy [SLOTS];
  logic              sl_done [SLOTS];
  logic [7:0]        sl_tag  [SLOTS];
  logic [20:0]       sl_size [SLOTS];
  logic [20:0]       sl_bytes[SLOTS];

  // latched request
  logic [2:0]  r_func;
  logic [47:0] r_addr;
  logic [20:0] r_size;
  logic [9:0]  r_reg;
  logic [7:0]  r_tag;
  logic        r_rdy, r_quash;
  logic [1:0]  r_rs;

  // sequencer
  logic [CW-1:0] idx;
  logic          q;         // queue being worked
  logic [SW:0]   s;         // slot index, wide enough for SLOTS
  logic [3:0]    ch, nch;
  logic [47:0]   caddr;
  logic          dmode;     // 1: shifting after removal in tick issue

  result_t res, ob;
  logic ob_v;

  function automatic result_t pack_res(logic [2:0] k, logic [47:0] ma, logic wr,
                                       logic [1:0] sl, logic [9:0] rg, logic fd,
                                       logic [7:0] tg, logic idl, logic [1:0] st,
                                       logic lst);
    result_t r;
    r.kind = k; r.mem_addr = ma; r.mem_write = wr; r.slot = sl; r.alias_reg = rg;
    r.found = fd; r.done_tag = tg; r.idle = idl; r.status = st; r.last = lst;
    return r;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !in_valid;
  assign out_valid = ob_v;
  assign kind = ob.kind; assign mem_addr = ob.mem_addr; assign mem_write = ob.mem_write;
  assign slot = ob.slot; assign alias_reg = ob.alias_reg; assign found = ob.found;
  assign done_tag = ob.done_tag; assign idle = ob.idle; assign status = ob.status;
  assign last = ob.last;

  logic [QW-1:0] ix;
  assign ix = idx[QW-1:0];
  logic [SW-1:0] sx;
  assign sx = s[SW-1:0];

  // chunk count, one shared compare/add per step
  logic [20:0] csz;
  logic [24:0] accum;

  logic [21:0] bsum;
  assign bsum = {1'b0, sl_bytes[r_rs]} + {9'd0, w};

  logic [15:0] cap;
  assign cap = {3'd0, w} * 16'(MAX_CHUNKS);

  logic any_busy;
  always_comb begin
    any_busy = 1'b0;
    for (int k = 0; k < SLOTS; k++) any_busy = any_busy | sl_busy[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret_state <= S_IDLE;
      ob_v <= 1'b0;
      request_width <= 13'd64;
      cnt[0] <= '0; cnt[1] <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        sl_busy[k] <= 1'b0; sl_done[k] <= 1'b0; sl_bytes[k] <= '0;
      end
    end else begin
      if (state == S_EMIT && (!ob_v || out_ready)) ob_v <= 1'b1;
      else if (ob_v && out_ready) ob_v <= 1'b0;
      if (cfg_valid && cfg_ready) request_width <= cfg_data;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_func <= func; r_addr <= addr; r_size <= size; r_reg <= phys_reg;
            r_tag <= instr_tag; r_rdy <= ready_now; r_quash <= quash_store;
            r_rs <= resp_slot;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          case (r_func)
            F_LOAD, F_STORE, F_SPILL: begin
              if (cnt[r_func != F_LOAD] >= CW'(QUEUE_DEPTH))
                res <= pack_res(K_ACK, 48'd0, 1'b0, 2'd0, 10'd0, 1'b0, 8'd0, 1'b0,
                                ST_FULL, 1'b1);
              else if (r_size == 21'd0 || r_size > 21'(SIZE_MAX_OK) ||
                       r_size > {5'd0, cap})
                res <= pack_res(K_ACK, 48'd0, 1'b0, 2'd0, 10'd0, 1'b0, 8'd0, 1'b0,
                                ST_SIZE, 1'b1);
              else begin
                res <= pack_res(K_ACK, 48'd0, 1'b0, 2'd0, 10'd0, 1'b0, 8'd0, 1'b0,
                                ST_OK, 1'b1);
                q_addr[r_func != F_LOAD][cnt[r_func != F_LOAD][QW-1:0]] <= r_addr;
                q_size[r_func != F_LOAD][cnt[r_func != F_LOAD][QW-1:0]] <= r_size;
                q_reg [r_func != F_LOAD][cnt[r_func != F_LOAD][QW-1:0]] <= r_reg;
                q_tag [r_func != F_LOAD][cnt[r_func != F_LOAD][QW-1:0]] <= r_tag;
                q_rdy [r_func != F_LOAD][cnt[r_func != F_LOAD][QW-1:0]] <= r_rdy;
                if (r_func != F_LOAD)
                  q_spill[cnt[1][QW-1:0]] <= (r_func == F_SPILL);
                cnt[r_func != F_LOAD] <= cnt[r_func != F_LOAD] + 1'b1;
              end
              ret_state <= S_IDLE; state <= S_EMIT;
            end
            F_SALIAS, F_LALIAS: begin
              q <= (r_func == F_SALIAS);
              idx <= cnt[r_func == F_SALIAS];
              state <= S_SCAN;
            end
            F_READY: begin
              q <= 1'b0; idx <= '0; state <= S_SCAN;
            end
            F_TICK: begin
              q <= 1'b0; s <= '0; state <= S_ISLOT;
            end
            default: state <= S_RESP;
          endcase
        end
        S_RESP: begin
          if (32'(r_rs) < SLOTS && sl_busy[r_rs]) begin
            sl_bytes[r_rs] <= bsum[21] ? 21'h1FFFFF : bsum[20:0];
            if ((bsum[21] ? 21'h1FFFFF : bsum[20:0]) >= sl_size[r_rs])
              sl_done[r_rs] <= 1'b1;
            res <= pack_res(K_ACK, 48'd0, 1'b0, r_rs, 10'd0, 1'b0, 8'd0, 1'b0,
                            ST_OK, 1'b1);
          end else begin
            res <= pack_res(K_ACK, 48'd0, 1'b0, r_rs, 10'd0, 1'b0, 8'd0, 1'b0,
                            ST_STRAY, 1'b1);
          end
          ret_state <= S_IDLE; state <= S_EMIT;
        end
        S_SCAN: begin
          if (r_func == F_READY) begin
            if (idx >= cnt[q]) begin
              if (!q) begin q <= 1'b1; idx <= '0; end
              else begin
                res <= pack_res(K_ACK, 48'd0, 1'b0, 2'd0, 10'd0, 1'b0, 8'd0, 1'b0,
                                ST_OK, 1'b1);
                ret_state <= S_IDLE; state <= S_EMIT;
              end
            end else begin
              if (q_tag[q][ix] == r_tag) q_rdy[q][ix] <= 1'b1;
              idx <= idx + 1'b1;
            end
          end else if (r_func == F_TICK) begin
            // oldest ready entry of queue q for slot s
            if (idx >= cnt[q]) begin
              if (!q) begin q <= 1'b1; s <= '0; state <= S_ISLOT; end
              else begin s <= '0; state <= S_RET; end
            end else if (q_rdy[q][ix]) begin
              caddr <= q_addr[q][ix];
              csz <= q_size[q][ix];
              sl_busy[sx] <= 1'b1; sl_tag[sx] <= q_tag[q][ix];
              sl_size[sx] <= q_size[q][ix]; sl_bytes[sx] <= '0; sl_done[sx] <= 1'b0;
              accum <= '0; ch <= '0;
              dmode <= 1'b1;
              state <= S_SHIFT;
            end else idx <= idx + 1'b1;
          end else begin
            // alias: walk youngest to oldest
            if (idx == '0) begin
              res <= pack_res(K_ALIAS, 48'd0, 1'b0, 2'd0, 10'd0, 1'b0, 8'd0, 1'b0,
                              ST_OK, 1'b1);
              ret_state <= S_IDLE; state <= S_EMIT;
            end else if (q_addr[q][QW'(idx - 1'b1)] == r_addr) begin
              res <= pack_res(K_ALIAS, 48'd0, 1'b0, 2'd0, q_reg[q][QW'(idx - 1'b1)],
                              1'b1, 8'd0, 1'b0, ST_OK, 1'b1);
              if (q && (r_quash || q_spill[QW'(idx - 1'b1)])) begin
                idx <= idx - 1'b1; dmode <= 1'b0; state <= S_SHIFT;
              end else begin
                ret_state <= S_IDLE; state <= S_EMIT;
              end
            end else idx <= idx - 1'b1;
          end
        end
        S_SHIFT: begin
          // compact queue q over entry idx, one entry per cycle
          if (idx + 1'b1 < cnt[q]) begin
            q_addr[q][ix] <= q_addr[q][QW'(idx + 1'b1)];
            q_size[q][ix] <= q_size[q][QW'(idx + 1'b1)];
            q_reg [q][ix] <= q_reg [q][QW'(idx + 1'b1)];
            q_tag [q][ix] <= q_tag [q][QW'(idx + 1'b1)];
            q_rdy [q][ix] <= q_rdy [q][QW'(idx + 1'b1)];
            if (q) q_spill[ix] <= q_spill[QW'(idx + 1'b1)];
            idx <= idx + 1'b1;
          end else begin
            cnt[q] <= cnt[q] - 1'b1;
            if (dmode) state <= S_CHUNK;
            else begin ret_state <= S_IDLE; state <= S_EMIT; end
          end
        end
        S_CHUNK: begin
          // emit chunk ch while ch*w < size and ch < MAX_CHUNKS
          if ({4'd0, csz} > accum && ch < 4'(MAX_CHUNKS)) begin
            res <= pack_res(K_MEM, caddr, q, sx, 10'd0, 1'b0, 8'd0, 1'b0, ST_OK, 1'b0);
            caddr <= caddr + {35'd0, w};
            accum <= accum + {12'd0, w};
            ch <= nch;
            ret_state <= S_CHUNK; state <= S_EMIT;
          end else begin
            s <= s + 1'b1; state <= S_ISLOT;
          end
        end
        S_ISLOT: begin
          if (s >= (SW+1)'(SLOTS)) begin
            if (!q) begin q <= 1'b1; s <= '0; end
            else begin s <= '0; state <= S_RET; end
          end else if (sl_busy[sx]) s <= s + 1'b1;
          else begin idx <= '0; state <= S_SCAN; end
        end
        S_RET: begin
          if (s >= (SW+1)'(SLOTS)) state <= S_TEND;
          else begin
            s <= s + 1'b1;
            if (sl_busy[sx] && sl_done[sx]) begin
              res <= pack_res(K_DONE, 48'd0, 1'b0, sx, 10'd0, 1'b0, sl_tag[sx], 1'b0,
                              ST_OK, 1'b0);
              sl_busy[sx] <= 1'b0; sl_done[sx] <= 1'b0;
              ret_state <= S_RET; state <= S_EMIT;
            end
          end
        end
        S_TEND: begin
          res <= pack_res(K_TEND, 48'd0, 1'b0, 2'd0, 10'd0, 1'b0, 8'd0,
                          (cnt[0] == '0) && (cnt[1] == '0) && !any_busy, ST_OK, 1'b1);
          ret_state <= S_IDLE; state <= S_EMIT;
        end
        S_EMIT: begin
          if (!ob_v || out_ready) begin
            ob <= res; state <= S_WAIT;
          end
        end
        S_WAIT: state <= ret_state;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign nch = ch + 1'b1;

  `LSQ_ASSERT_IMP(a_busy_not_ready, clk, rst, state != S_IDLE, !in_ready, "ready while busy")
  `LSQ_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1,
    cnt[0] <= CW'(QUEUE_DEPTH) && cnt[1] <= CW'(QUEUE_DEPTH), "queue count overflow")
  `LSQ_ASSERT_NXT(a_emit_loads, clk, rst, state == S_EMIT && (!ob_v || out_ready),
    ob_v, "result not loaded")
  `LSQ_ASSERT_IMP(a_chunk_cap, clk, rst, state == S_CHUNK, ch <= 4'(MAX_CHUNKS),
    "chunk count exceeds cap")
endmodule
`default_nettype wire
